FILE: rtl/quadratic_root_solver_defines.svh
// ---------------------------------------------------------------------------
// Quadratic root solver assertion macros
// Concurrent check wrappers that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`ifndef SYNTHESIS
`define QRS_ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define QRS_ASSERT(label, prop, msg) `QRS_ASSERT_CLK(label, clk, arst_n, prop, msg)
`else
`define QRS_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define QRS_ASSERT(label, prop, msg)
`endif
`endif

FILE: rtl/qrs_pkg.sv
// ---------------------------------------------------------------------------
// Quadratic root solver package
// Widths, kind codes and the sideband record shared by the pipeline modules.
// ---------------------------------------------------------------------------
`default_nettype none
package qrs_pkg;
	localparam int FRAC_BITS  = 16;
	localparam int COEF_W     = 32;
	localparam int PROD_W     = 2 * COEF_W;
	localparam int DISC_W     = PROD_W + 2;
	localparam int SQRT_STEPS = (DISC_W + 1) / 2;
	localparam int ROOT_W     = SQRT_STEPS;
	localparam int RAD_W      = 2 * SQRT_STEPS;
	localparam int REM_W      = ROOT_W + 4;
	localparam int NUM_W      = ROOT_W + 2;
	localparam int DEN_W      = COEF_W + 1;
	localparam int DVD_W      = NUM_W - 1 + FRAC_BITS;

	localparam logic [1:0] KIND_TWO_REAL = 2'd0;
	localparam logic [1:0] KIND_DOUBLE   = 2'd1;
	localparam logic [1:0] KIND_COMPLEX  = 2'd2;
	localparam logic [1:0] KIND_NO_LEAD  = 2'd3;

	typedef struct packed {
		logic [1:0]               kind;
		logic signed [COEF_W-1:0] b;
		logic                     a_neg;
		logic [DEN_W-1:0]         den;
	} side_t;
endpackage
`default_nettype wire

FILE: rtl/qrs_disc.sv
// ---------------------------------------------------------------------------
// Discriminant stages
// Two stages: magnitude products, then exact discriminant magnitude and kind.
// ---------------------------------------------------------------------------
`default_nettype none
module qrs_disc import qrs_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     in_valid,
	input  wire logic signed [COEF_W-1:0] coef_a,
	input  wire logic signed [COEF_W-1:0] coef_b,
	input  wire logic signed [COEF_W-1:0] coef_c,
	output logic                          out_valid,
	output logic [DISC_W-1:0]             disc,
	output side_t                         side
);
	logic [COEF_W-1:0] mag_a, mag_b, mag_c;
	logic [PROD_W-1:0] bb_c, ac_c;

	assign mag_a = coef_a[COEF_W-1] ? COEF_W'(-coef_a) : coef_a;
	assign mag_b = coef_b[COEF_W-1] ? COEF_W'(-coef_b) : coef_b;
	assign mag_c = coef_c[COEF_W-1] ? COEF_W'(-coef_c) : coef_c;
	assign bb_c  = mag_b * mag_b;
	assign ac_c  = mag_a * mag_c;

	logic                     vld_s1;
	logic [PROD_W-1:0]        bb_s1, ac_s1;
	logic                     opp_s1, no_lead_s1, a_neg_s1;
	logic signed [COEF_W-1:0] b_s1;
	logic [DEN_W-1:0]         den_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bb_s1      <= bb_c;
			ac_s1      <= ac_c;
			opp_s1     <= coef_a[COEF_W-1] ^ coef_c[COEF_W-1];
			no_lead_s1 <= (coef_a == '0);
			a_neg_s1   <= coef_a[COEF_W-1];
			b_s1       <= coef_b;
			// A zero leading coefficient is replaced by one so the divider stays defined.
			den_s1     <= (coef_a == '0) ? DEN_W'(1) : {mag_a, 1'b0};
		end
	end

	logic [DISC_W-1:0] bb_w, ac4_w, sum_w, dif_w, rdif_w, d_c;
	logic [1:0]        kind_c;

	assign bb_w   = {2'b00, bb_s1};
	assign ac4_w  = {ac_s1, 2'b00};
	assign sum_w  = bb_w + ac4_w;
	assign dif_w  = bb_w - ac4_w;
	assign rdif_w = ac4_w - bb_w;

	always_comb begin
		if (ac_s1 != '0 && opp_s1) begin
			d_c    = sum_w;
			kind_c = KIND_TWO_REAL;
		end else if (ac4_w == bb_w) begin
			d_c    = '0;
			kind_c = KIND_DOUBLE;
		end else if (ac4_w < bb_w) begin
			d_c    = dif_w;
			kind_c = KIND_TWO_REAL;
		end else begin
			d_c    = rdif_w;
			kind_c = KIND_COMPLEX;
		end
		if (no_lead_s1) begin
			kind_c = KIND_NO_LEAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			disc       <= d_c;
			side.kind  <= kind_c;
			side.b     <= b_s1;
			side.a_neg <= a_neg_s1;
			side.den   <= den_s1;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/qrs_sqrt.sv
// ---------------------------------------------------------------------------
// Pipelined square root
// Floor square root, one result bit per stage, sideband carried alongside.
// ---------------------------------------------------------------------------
`default_nettype none
module qrs_sqrt import qrs_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [DISC_W-1:0] disc,
	input  wire side_t             side_in,
	output logic                   out_valid,
	output logic [ROOT_W-1:0]      root,
	output side_t                  side_out
);
	logic              vld_s  [SQRT_STEPS];
	logic [REM_W-1:0]  rem_s  [SQRT_STEPS];
	logic [ROOT_W-1:0] root_s [SQRT_STEPS];
	logic [RAD_W-1:0]  rad_s  [SQRT_STEPS];
	side_t             side_s [SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam int P = 2 * (SQRT_STEPS - 1 - k);
		logic              vin;
		logic [REM_W-1:0]  rem_in, cur, trial;
		logic [ROOT_W-1:0] root_in;
		logic [RAD_W-1:0]  rad_in;
		side_t             sd_in;
		logic              ge;

		if (k == 0) begin : g_first
			assign vin     = in_valid;
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = RAD_W'(disc);
			assign sd_in   = side_in;
		end else begin : g_next
			assign vin     = vld_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign rad_in  = rad_s[k-1];
			assign sd_in   = side_s[k-1];
		end

		assign cur   = {rem_in[REM_W-3:0], rad_in[P+1:P]};
		assign trial = {2'b00, root_in, 2'b01};
		assign ge    = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? cur - trial : cur;
				root_s[k] <= {root_in[ROOT_W-2:0], ge};
				rad_s[k]  <= rad_in;
				side_s[k] <= sd_in;
			end
		end
	end

	assign out_valid = vld_s[SQRT_STEPS-1];
	assign root      = root_s[SQRT_STEPS-1];
	assign side_out  = side_s[SQRT_STEPS-1];
endmodule
`default_nettype wire

FILE: rtl/qrs_div.sv
// ---------------------------------------------------------------------------
// Pipelined divider
// Restoring division of |num| shifted by the fraction bits, one bit a stage.
// ---------------------------------------------------------------------------
`default_nettype none
module qrs_div import qrs_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic signed [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0]        den_mag,
	input  wire logic                    den_neg,
	output logic [DVD_W-1:0]             quot,
	output logic                         neg
);
	logic [NUM_W-1:0] num_mag;
	assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : num;

	// The word holds the dividend bits still to come on top and quotient bits below.
	logic [DVD_W-1:0] word_s [DVD_W];
	logic [DEN_W-1:0] rem_s  [DVD_W];
	logic [DEN_W-1:0] den_s  [DVD_W];
	logic             neg_s  [DVD_W];

	for (genvar k = 0; k < DVD_W; k++) begin : g_step
		logic [DVD_W-1:0] w_in;
		logic [DEN_W-1:0] r_in, d_in;
		logic             n_in, ge;
		logic [DEN_W:0]   cur;

		if (k == 0) begin : g_first
			assign w_in = {num_mag[NUM_W-2:0], {FRAC_BITS{1'b0}}};
			assign r_in = '0;
			assign d_in = den_mag;
			assign n_in = num[NUM_W-1] ^ den_neg;
		end else begin : g_next
			assign w_in = word_s[k-1];
			assign r_in = rem_s[k-1];
			assign d_in = den_s[k-1];
			assign n_in = neg_s[k-1];
		end

		assign cur = {r_in, w_in[DVD_W-1]};
		assign ge  = (cur >= {1'b0, d_in});

		always_ff @(posedge clk) begin
			if (en) begin
				word_s[k] <= {w_in[DVD_W-2:0], ge};
				rem_s[k]  <= ge ? DEN_W'(cur - {1'b0, d_in}) : DEN_W'(cur);
				den_s[k]  <= d_in;
				neg_s[k]  <= n_in;
			end
		end
	end

	assign quot = word_s[DVD_W-1];
	assign neg  = neg_s[DVD_W-1];
endmodule
`default_nettype wire

FILE: rtl/quadratic_root_solver.sv
// ---------------------------------------------------------------------------
// Quadratic root solver
// Roots of a*x^2 + b*x + c in signed Q16.16, exact discriminant, pipelined.
// ---------------------------------------------------------------------------
//
//   Channel | Handshake            | Payload
//   --------+----------------------+-----------------------------------------
//   input   | in_valid / in_ready  | coef_a, coef_b, coef_c
//   output  | out_valid / out_ready| root_kind, first_value, second_value,
//           |                      | saturated
//
// The pipeline has two discriminant stages, 33 square root stages, one
// numerator stage, 50 divider stages (one per quotient bit) and the output
// register. One coefficient set is taken every cycle while the output flows.
// The whole pipeline advances as one: it holds only when the output register
// holds a result that is not taken, so a stall loses and repeats nothing.
// Reset clears the valid bits only; no clearing pass is needed.
//
`include "quadratic_root_solver_defines.svh"
`default_nettype none
module quadratic_root_solver import qrs_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic signed [COEF_W-1:0] coef_a,
	input  wire logic signed [COEF_W-1:0] coef_b,
	input  wire logic signed [COEF_W-1:0] coef_c,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [1:0]                    root_kind,
	output logic signed [COEF_W-1:0]      first_value,
	output logic signed [COEF_W-1:0]      second_value,
	output logic                          saturated
);
	localparam logic [DVD_W-1:0] Q_POS_LIM = DVD_W'(64'h7FFF_FFFF);
	localparam logic [DVD_W-1:0] Q_NEG_LIM = DVD_W'(64'h8000_0000);

	// Every stage moves whenever the output register is empty or being emptied.
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	logic              disc_vld;
	logic [DISC_W-1:0] disc;
	side_t             disc_side;

	qrs_disc u_disc (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.coef_a    (coef_a),
		.coef_b    (coef_b),
		.coef_c    (coef_c),
		.out_valid (disc_vld),
		.disc      (disc),
		.side      (disc_side)
	);

	logic              sq_vld;
	logic [ROOT_W-1:0] sq_root;
	side_t             sq_side;

	qrs_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (disc_vld),
		.disc      (disc),
		.side_in   (disc_side),
		.out_valid (sq_vld),
		.root      (sq_root),
		.side_out  (sq_side)
	);

	// Numerators of the two quotients. The double root feeds -b to both
	// dividers; the complex pair divides -b and the root separately.
	logic signed [NUM_W-1:0] neg_b, root_x, n1_c, n2_c;
	assign neg_b  = -(NUM_W'(sq_side.b));
	assign root_x = $signed({2'b00, sq_root});

	always_comb begin
		case (sq_side.kind)
			KIND_TWO_REAL: begin
				n1_c = neg_b + root_x;
				n2_c = neg_b - root_x;
			end
			KIND_COMPLEX: begin
				n1_c = neg_b;
				n2_c = root_x;
			end
			default: begin
				n1_c = neg_b;
				n2_c = neg_b;
			end
		endcase
	end

	logic                    vld_s1;
	logic signed [NUM_W-1:0] n1_s1, n2_s1;
	logic [DEN_W-1:0]        den_s1;
	logic                    a_neg_s1;
	logic [1:0]              kind_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n1_s1    <= n1_c;
			n2_s1    <= n2_c;
			den_s1   <= sq_side.den;
			a_neg_s1 <= sq_side.a_neg;
			kind_s1  <= sq_side.kind;
		end
	end

	logic [DVD_W-1:0] q1, q2;
	logic             neg1, neg2;

	qrs_div u_div_first (
		.clk     (clk),
		.en      (en),
		.num     (n1_s1),
		.den_mag (den_s1),
		.den_neg (a_neg_s1),
		.quot    (q1),
		.neg     (neg1)
	);

	qrs_div u_div_second (
		.clk     (clk),
		.en      (en),
		.num     (n2_s1),
		.den_mag (den_s1),
		.den_neg (a_neg_s1),
		.quot    (q2),
		.neg     (neg2)
	);

	// Valid bits and kind codes run beside the dividers, one entry a stage.
	logic       vld_dv  [DVD_W];
	logic [1:0] kind_dv [DVD_W];

	for (genvar k = 0; k < DVD_W; k++) begin : g_tag
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_dv[k] <= 1'b0;
			end else if (en) begin
				vld_dv[k] <= (k == 0) ? vld_s1 : vld_dv[(k == 0) ? 0 : k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				kind_dv[k] <= (k == 0) ? kind_s1 : kind_dv[(k == 0) ? 0 : k-1];
			end
		end
	end

	// Clip a truncated quotient magnitude into the signed output range.
	// The result carries the clip flag above the 32-bit value.
	function automatic logic [COEF_W:0] clip(input logic [DVD_W-1:0] q, input logic n);
		logic [COEF_W:0] r;
		if (n) begin
			if (q > Q_NEG_LIM) begin
				r = {1'b1, Q_NEG_LIM[COEF_W-1:0]};
			end else begin
				r = {1'b0, COEF_W'(-q[COEF_W-1:0])};
			end
		end else begin
			if (q > Q_POS_LIM) begin
				r = {1'b1, Q_POS_LIM[COEF_W-1:0]};
			end else begin
				r = {1'b0, q[COEF_W-1:0]};
			end
		end
		return r;
	endfunction

	logic [COEF_W:0] c1, c2;
	logic [1:0]      kind_end;
	assign c1       = clip(q1, neg1);
	assign c2       = clip(q2, neg2);
	assign kind_end = kind_dv[DVD_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_dv[DVD_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			root_kind <= kind_end;
			if (kind_end == KIND_NO_LEAD) begin
				first_value  <= '0;
				second_value <= '0;
				saturated    <= 1'b0;
			end else begin
				first_value  <= $signed(c1[COEF_W-1:0]);
				second_value <= $signed(c2[COEF_W-1:0]);
				saturated    <= c1[COEF_W] | c2[COEF_W];
			end
		end
	end

	`QRS_ASSERT(a_no_lead_zero,
		out_valid && root_kind == KIND_NO_LEAD |->
		first_value == '0 && second_value == '0 && !saturated,
		"zero lead result not cleared")
	`QRS_ASSERT(a_double_same,
		out_valid && root_kind == KIND_DOUBLE |-> first_value == second_value,
		"double root values differ")
	`QRS_ASSERT(a_sat_extreme,
		out_valid && saturated |->
		first_value == 32'sh7FFF_FFFF || first_value == 32'sh8000_0000 ||
		second_value == 32'sh7FFF_FFFF || second_value == 32'sh8000_0000,
		"clip flag without clipped value")
endmodule
`default_nettype wire
